// ===== src/lpht_pkg.sv =====
`default_nettype none
package lpht_pkg;

  localparam int unsigned Capacity = 1024;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = 11;

  localparam logic [63:0] MixC1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixC2 = 64'h94d049bb133111eb;

  typedef enum logic [1:0] {
    OP_GET = 2'd0,
    OP_PUT = 2'd1,
    OP_REM = 2'd2,
    OP_CLR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_LIVE  = 2'd1,
    SLOT_TOMB  = 2'd2
  } slot_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] key;
    logic [63:0] value_in;
  } req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [63:0]     value_out;
    logic [CntW-1:0] entry_count;
    logic [63:0]     content_hash;
  } rsp_t;

  typedef enum logic [1:0] {
    MX_IDLE,
    MX_MUL1,
    MX_MUL2,
    MX_DONE
  } mix_state_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_HASH,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_DECIDE,
    S_MIX_OLD,
    S_MIX_NEW,
    S_MIX_KEY,
    S_WRITE,
    S_RESP
  } state_e;

  typedef struct packed {
    logic        start;
    logic [63:0] arg;
  } mix_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } mix_rsp_t;

endpackage
`default_nettype wire

// ===== src/linear_probe_hash_table.sv =====
`default_nettype none
// Each operation but clear hashes its key in the shared mixer, then probes slot by slot;
// get, refused put and missed remove end there. Put and remove that change the table run
// two more mixes in the shared multiplier for the content hash. Clear visits every slot.
// Throughput: one operation at a time, busy high until its result strobe.
// Reset: a clearing pass over all slots runs after reset with busy high, no strobe.
// The receiver cannot stall: the result stays on rsp_o from the strobe until the next start.
module linear_probe_hash_table (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire lpht_pkg::req_t       req_i,
  output logic                      done_o,
  output lpht_pkg::rsp_t            rsp_o,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [10:0]          cfg_data
);
  localparam int unsigned IdxW = lpht_pkg::IdxW;
  localparam int unsigned CntW = lpht_pkg::CntW;

  lpht_pkg::state_e state_q, state_d;
  lpht_pkg::req_t   req_q, req_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [IdxW:0]    n_q, n_d;
  logic [IdxW-1:0]  free_q, free_d;
  logic             free_v_q, free_v_d;
  logic             hit_q, hit_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [63:0]      hx_q, hx_d;
  logic [63:0]      old_v_q, old_v_d;
  logic [10:0]      max_q;
  logic [1:0]       st_q, st_d;
  logic [63:0]      vout_q, vout_d;

  logic                st_we, k_we, v_we;
  logic [IdxW-1:0]     waddr, raddr;
  logic [1:0]          st_wdata, st_rdata;
  logic [63:0]         v_wdata, k_rdata, v_rdata;
  lpht_pkg::mix_req_t  mreq;
  lpht_pkg::mix_rsp_t  mrsp;

  lpht_ram #(.Width(2), .Depth(lpht_pkg::Capacity)) u_status (
    .clk_i, .we_i(st_we), .waddr_i(waddr), .wdata_i(st_wdata),
    .raddr_i(raddr), .rdata_o(st_rdata));
  lpht_ram #(.Width(64), .Depth(lpht_pkg::Capacity)) u_keys (
    .clk_i, .we_i(k_we), .waddr_i(waddr), .wdata_i(req_q.key),
    .raddr_i(raddr), .rdata_o(k_rdata));
  lpht_ram #(.Width(64), .Depth(lpht_pkg::Capacity)) u_values (
    .clk_i, .we_i(v_we), .waddr_i(waddr), .wdata_i(v_wdata),
    .raddr_i(raddr), .rdata_o(v_rdata));

  lpht_mix u_mix (.clk_i, .rst_ni, .req_i(mreq), .rsp_o(mrsp));

  assign busy = (state_q != lpht_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_d = state_q;
    req_d = req_q;
    idx_d = idx_q;
    n_d = n_q;
    free_d = free_q;
    free_v_d = free_v_q;
    hit_d = hit_q;
    cnt_d = cnt_q;
    hx_d = hx_q;
    old_v_d = old_v_q;
    st_d = st_q;
    vout_d = vout_q;
    st_we = 1'b0;
    k_we = 1'b0;
    v_we = 1'b0;
    waddr = idx_q;
    st_wdata = lpht_pkg::SLOT_EMPTY;
    v_wdata = req_q.value_in;
    raddr = idx_q;
    mreq.start = 1'b0;
    mreq.arg = req_q.key;
    done_o = 1'b0;
    unique case (state_q)
      lpht_pkg::S_IDLE: begin
        if (start) begin
          req_d = req_i;
          st_d = lpht_pkg::ST_OK;
          vout_d = '0;
          hit_d = 1'b0;
          free_v_d = 1'b0;
          n_d = '0;
          idx_d = '0;
          if (req_i.opcode == lpht_pkg::OP_CLR) begin
            state_d = lpht_pkg::S_CLEAR;
          end else begin
            mreq.start = 1'b1;
            mreq.arg = req_i.key;
            state_d = lpht_pkg::S_HASH;
          end
        end
      end
      lpht_pkg::S_CLEAR: begin
        st_we = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_q == IdxW'(lpht_pkg::Capacity - 1)) begin
          cnt_d = '0;
          hx_d = '0;
          // the pass after reset ends without a result word
          if (req_q.opcode == lpht_pkg::OP_CLR) begin
            state_d = lpht_pkg::S_RESP;
          end else begin
            state_d = lpht_pkg::S_IDLE;
          end
        end
      end
      lpht_pkg::S_HASH: begin
        if (mrsp.done) begin
          idx_d = mrsp.res[IdxW-1:0];
          state_d = lpht_pkg::S_PROBE_RD;
        end
      end
      lpht_pkg::S_PROBE_RD: begin
        state_d = lpht_pkg::S_PROBE_CHK;
      end
      lpht_pkg::S_PROBE_CHK: begin
        // memory read of idx_q is now valid
        if (st_rdata == lpht_pkg::SLOT_EMPTY) begin
          if (!free_v_q) begin
            free_d = idx_q;
            free_v_d = 1'b1;
          end
          state_d = lpht_pkg::S_DECIDE;
        end else if (st_rdata == lpht_pkg::SLOT_LIVE && k_rdata == req_q.key) begin
          hit_d = 1'b1;
          old_v_d = v_rdata;
          state_d = lpht_pkg::S_DECIDE;
        end else begin
          if (st_rdata != lpht_pkg::SLOT_LIVE && !free_v_q) begin
            free_d = idx_q;
            free_v_d = 1'b1;
          end
          idx_d = idx_q + 1'b1;
          n_d = n_q + 1'b1;
          if (n_q == (IdxW+1)'(lpht_pkg::Capacity - 1)) begin
            state_d = lpht_pkg::S_DECIDE;
          end else begin
            state_d = lpht_pkg::S_PROBE_RD;
          end
        end
      end
      lpht_pkg::S_DECIDE: begin
        state_d = lpht_pkg::S_RESP;
        unique case (req_q.opcode)
          lpht_pkg::OP_GET: begin
            if (hit_q) vout_d = old_v_q;
            else st_d = lpht_pkg::ST_MISSING;
          end
          lpht_pkg::OP_PUT: begin
            if (hit_q) begin
              mreq.start = 1'b1;
              mreq.arg = old_v_q;
              state_d = lpht_pkg::S_MIX_OLD;
            end else if ((CntW'(cnt_q) >= max_q) || !free_v_q) begin
              st_d = lpht_pkg::ST_FULL;
            end else begin
              idx_d = free_q;
              mreq.start = 1'b1;
              mreq.arg = req_q.key;
              state_d = lpht_pkg::S_MIX_KEY;
            end
          end
          lpht_pkg::OP_REM: begin
            if (hit_q) begin
              mreq.start = 1'b1;
              mreq.arg = req_q.key;
              state_d = lpht_pkg::S_MIX_KEY;
            end else begin
              st_d = lpht_pkg::ST_MISSING;
            end
          end
          default: ;
        endcase
      end
      lpht_pkg::S_MIX_KEY: begin
        if (mrsp.done) begin
          hx_d = hx_q ^ mrsp.res;
          mreq.start = 1'b1;
          mreq.arg = (req_q.opcode == lpht_pkg::OP_REM) ? old_v_q : req_q.value_in;
          state_d = lpht_pkg::S_MIX_NEW;
        end
      end
      lpht_pkg::S_MIX_OLD: begin
        if (mrsp.done) begin
          hx_d = hx_q ^ mrsp.res;
          mreq.start = 1'b1;
          mreq.arg = req_q.value_in;
          state_d = lpht_pkg::S_MIX_NEW;
        end
      end
      lpht_pkg::S_MIX_NEW: begin
        if (mrsp.done) begin
          hx_d = hx_q ^ mrsp.res;
          state_d = lpht_pkg::S_WRITE;
        end
      end
      lpht_pkg::S_WRITE: begin
        v_we = 1'b1;
        if (req_q.opcode == lpht_pkg::OP_REM) begin
          st_we = 1'b1;
          st_wdata = lpht_pkg::SLOT_TOMB;
          v_wdata = '0;
          cnt_d = cnt_q - 1'b1;
        end else if (!hit_q) begin
          st_we = 1'b1;
          k_we = 1'b1;
          st_wdata = lpht_pkg::SLOT_LIVE;
          cnt_d = cnt_q + 1'b1;
        end
        state_d = lpht_pkg::S_RESP;
      end
      lpht_pkg::S_RESP: begin
        done_o = 1'b1;
        state_d = lpht_pkg::S_IDLE;
      end
      default: state_d = lpht_pkg::S_IDLE;
    endcase
  end

  assign rsp_o.status = st_q;
  assign rsp_o.value_out = vout_q;
  assign rsp_o.entry_count = cnt_q;
  assign rsp_o.content_hash = hx_q ^ {53'd0, cnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpht_pkg::S_CLEAR;
      idx_q <= '0;
      n_q <= '0;
      cnt_q <= '0;
      hx_q <= '0;
      max_q <= 11'd768;
      free_v_q <= 1'b0;
      hit_q <= 1'b0;
      req_q <= '0;
      st_q <= lpht_pkg::ST_OK;
      vout_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      n_q <= n_d;
      cnt_q <= cnt_d;
      hx_q <= hx_d;
      free_v_q <= free_v_d;
      hit_q <= hit_d;
      req_q <= req_d;
      st_q <= st_d;
      vout_q <= vout_d;
      if (cfg_valid) max_q <= cfg_data;
    end
  end

  always_ff @(posedge clk_i) begin
    free_q <= free_d;
    old_v_q <= old_v_d;
  end
endmodule
`default_nettype wire

// ===== src/lpht_ram.sv =====
`default_nettype none
module lpht_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== src/lpht_mix.sv =====
`default_nettype none
// splitmix64 finalizer, two 64x64 multiplies per pass, each split in 32-bit partial products
module lpht_mix (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lpht_pkg::mix_req_t req_i,
  output lpht_pkg::mix_rsp_t     rsp_o
);
  lpht_pkg::mix_state_e state_q, state_d;
  logic [63:0] x_q, x_d;
  logic [63:0] c_q, c_d;
  logic [63:0] acc_q, acc_d;
  logic [1:0]  ph_q, ph_d;
  logic [31:0] a_sel, b_sel;
  logic [63:0] prod;

  // partial products: lo*lo, lo*hi, hi*lo (hi*hi drops out of 64 bits)
  always_comb begin
    a_sel = x_q[31:0];
    b_sel = c_q[31:0];
    unique case (ph_q)
      2'd1: b_sel = c_q[63:32];
      2'd2: a_sel = x_q[63:32];
      default: ;
    endcase
    prod = {32'd0, a_sel} * {32'd0, b_sel};
  end

  always_comb begin
    state_d = state_q;
    x_d = x_q;
    c_d = c_q;
    acc_d = acc_q;
    ph_d = ph_q;
    rsp_o.done = 1'b0;
    rsp_o.res = x_q;
    unique case (state_q)
      lpht_pkg::MX_IDLE: begin
        if (req_i.start) begin
          x_d = req_i.arg ^ (req_i.arg >> 30);
          c_d = lpht_pkg::MixC1;
          acc_d = '0;
          ph_d = 2'd0;
          state_d = lpht_pkg::MX_MUL1;
        end
      end
      lpht_pkg::MX_MUL1, lpht_pkg::MX_MUL2: begin
        if (ph_q == 2'd0) begin
          acc_d = prod;
        end else begin
          acc_d = acc_q + {prod[31:0], 32'd0};
        end
        ph_d = ph_q + 2'd1;
        if (ph_q == 2'd2) begin
          ph_d = 2'd0;
          if (state_q == lpht_pkg::MX_MUL1) begin
            x_d = acc_d ^ (acc_d >> 27);
            c_d = lpht_pkg::MixC2;
            state_d = lpht_pkg::MX_MUL2;
          end else begin
            x_d = acc_d ^ (acc_d >> 31);
            state_d = lpht_pkg::MX_DONE;
          end
        end
      end
      lpht_pkg::MX_DONE: begin
        rsp_o.done = 1'b1;
        state_d = lpht_pkg::MX_IDLE;
        // take a chained request in the same cycle as the result
        if (req_i.start) begin
          x_d = req_i.arg ^ (req_i.arg >> 30);
          c_d = lpht_pkg::MixC1;
          acc_d = '0;
          ph_d = 2'd0;
          state_d = lpht_pkg::MX_MUL1;
        end
      end
      default: state_d = lpht_pkg::MX_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpht_pkg::MX_IDLE;
      ph_q <= 2'd0;
    end else begin
      state_q <= state_d;
      ph_q <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    c_q <= c_d;
    acc_q <= acc_d;
  end
endmodule
`default_nettype wire

// ===== src/lpht_checker.sv =====
`default_nettype none
module lpht_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           done_o,
  input wire lpht_pkg::rsp_t rsp_o
);
  // a result strobe ends the operation
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("strobe while idle");
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("busy after strobe");
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted word not busy");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.status <= lpht_pkg::ST_FULL)) else $error("bad status");
  a_vout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != lpht_pkg::ST_OK) |-> (rsp_o.value_out == 64'd0))
    else $error("value on miss");
endmodule

bind linear_probe_hash_table lpht_checker u_chk (
  .clk_i, .rst_ni, .start, .busy, .done_o, .rsp_o);
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;

  localparam int MaxIdle = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  lpht_pkg::req_t req_i = '0;
  logic done_o;
  lpht_pkg::rsp_t rsp_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [10:0] cfg_data = '0;

  linear_probe_hash_table u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .done_o(done_o), .rsp_o(rsp_o), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // shadow table
  logic [63:0]     tbl_key [lpht_pkg::Capacity];
  logic [63:0]     tbl_val [lpht_pkg::Capacity];
  lpht_pkg::slot_e tbl_st  [lpht_pkg::Capacity];
  int unsigned tbl_count;
  logic [63:0] tbl_xor;
  logic [10:0] tbl_limit;

  lpht_pkg::req_t pending_q[$];
  lpht_pkg::rsp_t expected_q[$];
  logic [63:0] used_keys[$];
  int unsigned n_errors, n_checked, n_sent, idle_cycles;
  int unsigned n_full, n_found, n_missing;

  function automatic logic [63:0] splitmix(logic [63:0] x);
    x = (x ^ (x >> 30)) * 64'hbf58476d1ce4e5b9;
    x = (x ^ (x >> 27)) * 64'h94d049bb133111eb;
    return x ^ (x >> 31);
  endfunction

  function automatic void table_reset();
    for (int i = 0; i < lpht_pkg::Capacity; i++) tbl_st[i] = lpht_pkg::SLOT_EMPTY;
    tbl_count = 0;
    tbl_xor = '0;
  endfunction

  function automatic lpht_pkg::rsp_t table_apply(lpht_pkg::req_t r);
    lpht_pkg::rsp_t o;
    int hit, free_idx;
    int unsigned idx;
    o = '0;
    o.status = lpht_pkg::ST_OK;
    if (lpht_pkg::op_e'(r.opcode) == lpht_pkg::OP_CLR) begin
      table_reset();
    end else begin
      hit = -1;
      free_idx = -1;
      idx = splitmix(r.key) % lpht_pkg::Capacity;
      for (int n = 0; n < lpht_pkg::Capacity; n++) begin
        if (tbl_st[idx] == lpht_pkg::SLOT_EMPTY) begin
          if (free_idx < 0) free_idx = idx;
          break;
        end
        if (tbl_st[idx] == lpht_pkg::SLOT_LIVE && tbl_key[idx] == r.key) begin
          hit = idx;
          break;
        end
        if (tbl_st[idx] != lpht_pkg::SLOT_LIVE && free_idx < 0) free_idx = idx;
        idx = (idx + 1) % lpht_pkg::Capacity;
      end
      case (lpht_pkg::op_e'(r.opcode))
        lpht_pkg::OP_GET: begin
          if (hit >= 0) o.value_out = tbl_val[hit];
          else o.status = lpht_pkg::ST_MISSING;
        end
        lpht_pkg::OP_PUT: begin
          if (hit >= 0) begin
            tbl_xor ^= splitmix(tbl_val[hit]) ^ splitmix(r.value_in);
            tbl_val[hit] = r.value_in;
          end else if (tbl_count >= tbl_limit || free_idx < 0) begin
            o.status = lpht_pkg::ST_FULL;
          end else begin
            tbl_key[free_idx] = r.key;
            tbl_val[free_idx] = r.value_in;
            tbl_st[free_idx] = lpht_pkg::SLOT_LIVE;
            tbl_count++;
            tbl_xor ^= splitmix(r.key) ^ splitmix(r.value_in);
          end
        end
        default: begin
          if (hit >= 0) begin
            tbl_xor ^= splitmix(tbl_key[hit]) ^ splitmix(tbl_val[hit]);
            tbl_st[hit] = lpht_pkg::SLOT_TOMB;
            tbl_val[hit] = '0;
            tbl_count--;
          end else begin
            o.status = lpht_pkg::ST_MISSING;
          end
        end
      endcase
    end
    o.entry_count = tbl_count[10:0];
    o.content_hash = tbl_xor ^ 64'(tbl_count);
    return o;
  endfunction

  // set at the edge where the current word was accepted
  logic busy_seen = 1'b1;

  // driver: bursts with random gaps
  int unsigned burst_left = 0, gap_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy_seen) begin
        // still waiting for acceptance
      end else if (pending_q.size() == 0) begin
        start <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else begin
        req_i <= pending_q.pop_front();
        start <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(12, 1);
          gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(15, 0);
        end else begin
          burst_left--;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (start && !busy) begin
      busy_seen <= 1'b1;
      expected_q.push_back(table_apply(req_i));
      n_sent++;
    end else if (start) begin
      busy_seen <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o || (cfg_valid && cfg_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (done_o) begin
        n_checked++;
        if (expected_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("ERROR: unexpected result %p", rsp_o);
        end else begin
          automatic lpht_pkg::rsp_t e = expected_q.pop_front();
          case (e.status)
            lpht_pkg::ST_FULL: n_full++;
            lpht_pkg::ST_MISSING: n_missing++;
            default: n_found++;
          endcase
          if (rsp_o.status !== e.status || rsp_o.value_out !== e.value_out ||
              rsp_o.entry_count !== e.entry_count ||
              rsp_o.content_hash !== e.content_hash) begin
            n_errors++;
            if (n_errors <= 10)
              $display("ERROR: status %0d/%0d value %h/%h count %0d/%0d hash %h/%h",
                       e.status, rsp_o.status, e.value_out, rsp_o.value_out,
                       e.entry_count, rsp_o.entry_count, e.content_hash,
                       rsp_o.content_hash);
          end
        end
      end
      if (idle_cycles >= MaxIdle) begin
        $display("timeout with %0d pending", expected_q.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic set_limit(logic [10:0] lim);
    @(negedge clk_i);
    cfg_data <= lim;
    cfg_valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    tbl_limit = lim;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || start || expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic void add(lpht_pkg::op_e op, logic [63:0] k, logic [63:0] v);
    lpht_pkg::req_t r;
    r.opcode = op;
    r.key = k;
    r.value_in = v;
    pending_q.push_back(r);
    if (op == lpht_pkg::OP_PUT) used_keys.push_back(k);
  endfunction

  function automatic logic [63:0] pick_key(int unsigned pool);
    if (used_keys.size() == 0 || $urandom_range(3, 0) == 0) begin
      if (pool != 0) return 64'($urandom_range(pool - 1, 0));
      return rand64();
    end
    return used_keys[$urandom_range(used_keys.size() - 1, 0)];
  endfunction

  task automatic random_phase(int unsigned n, int unsigned pool, int unsigned clr_rate);
    int unsigned w;
    for (int i = 0; i < n; i++) begin
      w = $urandom_range(99, 0);
      if (w < clr_rate) add(lpht_pkg::OP_CLR, rand64(), rand64());
      else if (w < 45) add(lpht_pkg::OP_PUT, pick_key(pool), rand64());
      else if (w < 75) add(lpht_pkg::OP_GET, pick_key(pool), rand64());
      else add(lpht_pkg::OP_REM, pick_key(pool), rand64());
    end
    drain();
  endtask

  initial begin
    n_errors = 0; n_checked = 0; n_sent = 0; idle_cycles = 0;
    n_full = 0; n_found = 0; n_missing = 0;
    tbl_limit = 11'd768;
    table_reset();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, every op, update, absent key, tombstone reuse, clear
    add(lpht_pkg::OP_GET, '0, '0);
    add(lpht_pkg::OP_PUT, '0, '1);
    add(lpht_pkg::OP_PUT, '1, '0);
    add(lpht_pkg::OP_GET, '0, '0);
    add(lpht_pkg::OP_GET, '1, '1);
    add(lpht_pkg::OP_PUT, '0, 64'h5555_aaaa_5555_aaaa);
    add(lpht_pkg::OP_GET, '0, '0);
    add(lpht_pkg::OP_REM, 64'h1234, '0);
    add(lpht_pkg::OP_REM, '0, '0);
    add(lpht_pkg::OP_GET, '0, '0);
    add(lpht_pkg::OP_REM, '0, '0);
    add(lpht_pkg::OP_PUT, '0, 64'haaaa_5555_aaaa_5555);
    add(lpht_pkg::OP_PUT, 64'h8000_0000_0000_0000, 64'h1);
    add(lpht_pkg::OP_CLR, '1, '1);
    add(lpht_pkg::OP_GET, '1, '0);
    drain();

    // limit zero refuses new keys; limit one allows just one
    set_limit(11'd0);
    add(lpht_pkg::OP_PUT, 64'd7, 64'd7);
    add(lpht_pkg::OP_GET, 64'd7, '0);
    drain();
    set_limit(11'd1);
    add(lpht_pkg::OP_PUT, 64'd7, 64'd7);
    add(lpht_pkg::OP_PUT, 64'd8, 64'd8);
    add(lpht_pkg::OP_PUT, 64'd7, 64'd9);
    add(lpht_pkg::OP_CLR, '0, '0);
    drain();

    set_limit(11'd768);
    random_phase(40, 0, 2);
    set_limit(11'd16);
    random_phase(30, 64, 3);
    set_limit(11'd2047);
    // fill beyond capacity to reach the no-free-slot case
    for (int i = 0; i < 1030; i++) add(lpht_pkg::OP_PUT, rand64(), rand64());
    drain();
    random_phase(15, 0, 0);
    set_limit(11'd1024);
    random_phase(15, 32, 4);

    $display("Sent %0d operations, checked %0d results", n_sent, n_checked);
    $display("ok %0d, not found %0d, full %0d", n_found, n_missing, n_full);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== linear_probe_hash_table.f =====
src/lpht_pkg.sv
src/lpht_ram.sv
src/lpht_mix.sv
src/linear_probe_hash_table.sv
src/lpht_checker.sv
sim/tb.sv
